>>> rtl/ssbs_pkg.sv
// Shared constants and types for the SQL statement boundary scanner.
`timescale 1ns / 1ps

package ssbs_pkg;

  localparam int unsigned DefMaxBoundaries = 64;
  localparam int unsigned DefMaxTagLen     = 16;
  localparam int unsigned DefPosWidth      = 16;

  localparam int unsigned OffsetW = 16;
  localparam int unsigned CountW  = 7;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic signed [7:0] DEPTH_MAX = 8'sh7F;
  localparam logic signed [7:0] DEPTH_MIN = 8'sh80;

  typedef enum logic [9:0] {
    M_NORMAL      = 10'b00_0000_0001,
    M_SLASH       = 10'b00_0000_0010,
    M_CCOMMENT    = 10'b00_0000_0100,
    M_STAR        = 10'b00_0000_1000,
    M_SQUOTE      = 10'b00_0001_0000,
    M_DQUOTE      = 10'b00_0010_0000,
    M_TAG_OPEN    = 10'b00_0100_0000,
    M_DOLLAR_BODY = 10'b00_1000_0000,
    M_TAG_CLOSE   = 10'b01_0000_0000,
    M_LINE        = 10'b10_0000_0000
  } scan_mode_t;

  function automatic logic signed [7:0] depth_up(input logic signed [7:0] d);
    depth_up = (d != DEPTH_MAX) ? d + 8'sd1 : d;
  endfunction

  function automatic logic signed [7:0] depth_down(input logic signed [7:0] d);
    depth_down = (d != DEPTH_MIN) ? d - 8'sd1 : d;
  endfunction

endpackage

>>> rtl/sql_statement_boundary_scanner.sv
// Top level: byte-wide SQL statement boundary scanner with registered result.
//
//   channel  ports                                   role
//   in       in_valid / in_ready, in_text_byte       one text byte per word
//   out      out_valid / out_ready, out_boundary,    one result word per byte
//            out_boundary_offset, out_statement_count,
//            out_text_end, out_limit_reached
//
// One byte per cycle unless out_ready stalls: scan state and output register
// both load at the accepting edge; the result word is valid the cycle after.
// The closing-tag compare uses the tag byte fetched at the previous accept.
// in_ready is high whenever the output register is empty or being drained,
// so a stalled out_ready holds at most one result and stops input.
// Reset (rst_n low, synchronous) clears the scan state and the output valid;
// the dollar-tag store is not reset and is only read after being written.
`timescale 1ns / 1ps

module sql_statement_boundary_scanner
  import ssbs_pkg::*;
#(
  parameter int unsigned MAX_BOUNDARIES = DefMaxBoundaries,
  parameter int unsigned MAX_TAG_LEN    = DefMaxTagLen,
  parameter int unsigned POS_WIDTH      = DefPosWidth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_text_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_boundary,
  output logic [OffsetW-1:0]   out_boundary_offset,
  output logic [CountW-1:0]    out_statement_count,
  output logic                 out_text_end,
  output logic                 out_limit_reached
);

  localparam int unsigned CNT_W = $clog2(MAX_BOUNDARIES + 1);
  localparam int unsigned TL_W  = $clog2(MAX_TAG_LEN + 2);
  localparam int unsigned TAG_IW = (MAX_TAG_LEN > 1) ? $clog2(MAX_TAG_LEN) : 1;

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_BOUNDARIES);
  localparam logic [TL_W-1:0]  TAG_MAX   = TL_W'(MAX_TAG_LEN);

  // scan state
  scan_mode_t        mode_r, mode_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic signed [7:0] paren_r, paren_nxt;
  logic signed [7:0] brack_r, brack_nxt;
  logic signed [7:0] brace_r, brace_nxt;
  logic              esc_r, esc_nxt;
  logic              dash_r, dash_nxt;
  logic [TL_W-1:0]   tag_len_r, tag_len_nxt;
  logic [TL_W-1:0]   close_idx_r, close_idx_nxt;
  logic              mismatch_r, mismatch_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [7:0]        tag_mem [MAX_TAG_LEN];

  // result register
  logic                 out_valid_r;
  logic                 bnd_r, bnd_nxt;
  logic [OffsetW-1:0]   off_r, off_nxt;
  logic [CountW-1:0]    scount_r, scount_nxt;
  logic                 end_r, end_nxt;
  logic                 limit_r, limit_nxt;

  logic                 accept;
  logic                 ws;
  logic                 consumed;
  scan_mode_t           mode_eff;
  logic                 tag_we;
  logic [POS_WIDTH-1:0] pos_inc;
  logic [POS_WIDTH-1:0] off_full;
  logic [POS_WIDTH+OffsetW-1:0] off_ext;
  logic [CNT_W+CountW-1:0]      cnt_ext;
  logic [7:0]           tag_rd_r;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign ws       = (in_text_byte == CH_SPACE) || (in_text_byte == CH_LF) ||
                    (in_text_byte == CH_CR);
  assign pos_inc  = pos_r + POS_WIDTH'(1);

  // a pending slash either opens a comment or falls back to normal context
  always_comb begin
    consumed = 1'b0;
    mode_eff = mode_r;
    if (mode_r == M_SLASH) begin
      if (in_text_byte == CH_STAR) begin
        consumed = 1'b1;
        mode_eff = M_CCOMMENT;
      end else begin
        mode_eff = M_NORMAL;
      end
    end
  end

  always_comb begin
    mode_nxt      = mode_eff;
    pos_nxt       = pos_inc;
    paren_nxt     = paren_r;
    brack_nxt     = brack_r;
    brace_nxt     = brace_r;
    esc_nxt       = 1'b0;
    dash_nxt      = 1'b0;
    tag_len_nxt   = tag_len_r;
    close_idx_nxt = close_idx_r;
    mismatch_nxt  = mismatch_r;
    count_nxt     = count_r;
    tag_we        = 1'b0;
    bnd_nxt       = 1'b0;
    off_full      = '0;
    end_nxt       = 1'b0;

    if (in_text_byte == CH_NUL) begin
      // end of text: last boundary if under the limit, then clear everything
      end_nxt = 1'b1;
      if (count_r < CNT_LIMIT) begin
        bnd_nxt   = 1'b1;
        off_full  = pos_r;
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (!consumed) begin
      unique case (mode_eff)
        M_NORMAL: begin
          case (in_text_byte)
            CH_LPAREN: paren_nxt = depth_up(paren_r);
            CH_RPAREN: paren_nxt = depth_down(paren_r);
            CH_LBRACK: brack_nxt = depth_up(brack_r);
            CH_RBRACK: brack_nxt = depth_down(brack_r);
            CH_LBRACE: brace_nxt = depth_up(brace_r);
            CH_RBRACE: brace_nxt = depth_down(brace_r);
            CH_SLASH:  mode_nxt  = M_SLASH;
            CH_DQUOTE: mode_nxt  = M_DQUOTE;
            CH_SQUOTE: mode_nxt  = M_SQUOTE;
            CH_DOLLAR: begin
              mode_nxt    = M_TAG_OPEN;
              tag_len_nxt = '0;
            end
            CH_DASH: begin
              if (dash_r) mode_nxt = M_LINE;
              else dash_nxt = 1'b1;
            end
            CH_SEMI: begin
              if (paren_r == 8'sd0 && brack_r == 8'sd0 && brace_r == 8'sd0 &&
                  count_r < CNT_LIMIT) begin
                bnd_nxt   = 1'b1;
                off_full  = pos_inc;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
        M_CCOMMENT: begin
          if (in_text_byte == CH_STAR) mode_nxt = M_STAR;
        end
        M_STAR: begin
          if (in_text_byte == CH_SLASH) mode_nxt = M_NORMAL;
          else if (in_text_byte != CH_STAR) mode_nxt = M_CCOMMENT;
        end
        M_SQUOTE, M_DQUOTE: begin
          if (in_text_byte == CH_BSLASH) begin
            esc_nxt = !esc_r;
          end else if ((in_text_byte == CH_SQUOTE && mode_eff == M_SQUOTE) ||
                       (in_text_byte == CH_DQUOTE && mode_eff == M_DQUOTE)) begin
            if (!esc_r) mode_nxt = M_NORMAL;
          end
        end
        M_TAG_OPEN: begin
          if (in_text_byte == CH_DOLLAR) begin
            mode_nxt = M_DOLLAR_BODY;
          end else if (ws) begin
            mode_nxt = M_NORMAL;
          end else begin
            tag_we = (tag_len_r < TAG_MAX);
            if (tag_len_r <= TAG_MAX) tag_len_nxt = tag_len_r + TL_W'(1);
          end
        end
        M_DOLLAR_BODY: begin
          if (in_text_byte == CH_DOLLAR) begin
            mode_nxt      = M_TAG_CLOSE;
            close_idx_nxt = '0;
            mismatch_nxt  = 1'b0;
          end
        end
        M_TAG_CLOSE: begin
          if (in_text_byte == CH_DOLLAR) begin
            if (close_idx_r == tag_len_r && !mismatch_r) mode_nxt = M_NORMAL;
            else mode_nxt = M_DOLLAR_BODY;
          end else if (ws) begin
            mode_nxt = M_DOLLAR_BODY;
          end else begin
            // compare one tag byte per cycle while bytes are accepted
            if (close_idx_r < tag_len_r && close_idx_r < TAG_MAX &&
                tag_rd_r != in_text_byte) begin
              mismatch_nxt = 1'b1;
            end
            if (close_idx_r <= TAG_MAX) close_idx_nxt = close_idx_r + TL_W'(1);
          end
        end
        M_LINE: begin
          if (in_text_byte == CH_LF || in_text_byte == CH_CR) mode_nxt = M_NORMAL;
        end
        default: mode_nxt = M_NORMAL;
      endcase
    end

    off_ext    = {{OffsetW{1'b0}}, off_full};
    off_nxt    = off_ext[OffsetW-1:0];
    cnt_ext    = {{CountW{1'b0}}, count_nxt};
    scount_nxt = cnt_ext[CountW-1:0];
    limit_nxt  = (count_nxt >= CNT_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_NORMAL;
      pos_r       <= '0;
      paren_r     <= '0;
      brack_r     <= '0;
      brace_r     <= '0;
      esc_r       <= 1'b0;
      dash_r      <= 1'b0;
      tag_len_r   <= '0;
      close_idx_r <= '0;
      mismatch_r  <= 1'b0;
      count_r     <= '0;
    end else if (accept) begin
      if (in_text_byte == CH_NUL) begin
        mode_r      <= M_NORMAL;
        pos_r       <= '0;
        paren_r     <= '0;
        brack_r     <= '0;
        brace_r     <= '0;
        esc_r       <= 1'b0;
        dash_r      <= 1'b0;
        tag_len_r   <= '0;
        close_idx_r <= '0;
        mismatch_r  <= 1'b0;
        count_r     <= '0;
      end else begin
        mode_r      <= mode_nxt;
        pos_r       <= pos_nxt;
        paren_r     <= paren_nxt;
        brack_r     <= brack_nxt;
        brace_r     <= brace_nxt;
        esc_r       <= esc_nxt;
        dash_r      <= dash_nxt;
        tag_len_r   <= tag_len_nxt;
        close_idx_r <= close_idx_nxt;
        mismatch_r  <= mismatch_nxt;
        count_r     <= count_nxt;
      end
    end
  end

  // fetch the tag byte that the next closing-tag byte is compared against
  always_ff @(posedge clk) begin
    if (accept && tag_we) begin
      tag_mem[tag_len_r[TAG_IW-1:0]] <= in_text_byte;
    end
    if (accept) begin
      tag_rd_r <= tag_mem[close_idx_nxt[TAG_IW-1:0]];
    end
  end

  // result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bnd_r    <= bnd_nxt;
      off_r    <= off_nxt;
      scount_r <= scount_nxt;
      end_r    <= end_nxt;
      limit_r  <= limit_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_boundary        = bnd_r;
  assign out_boundary_offset = off_r;
  assign out_statement_count = scount_r;
  assign out_text_end        = end_r;
  assign out_limit_reached   = limit_r;

endmodule
